// File: src/stli_pkg.sv
// ----------------------------------------------------------------------------
// stli_pkg: shared types and constants of the sorted table interpolator
// Holds word width, fixed-point one, opcodes, status codes and FSM states.
// ----------------------------------------------------------------------------
package stli_pkg;

  localparam int VW = 48;
  localparam int FRAC_BITS = 16;
  localparam int MAX_ROWS_DEFAULT = 64;
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] ROW_COUNT_RESET = 7'd64;
  localparam logic [VW-1:0] FIXED_ONE = VW'(64'd1 << FRAC_BITS);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic [1:0] KEY_COL = 2'd0;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FAIL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK_LO, S_CHK_HI, S_SRCH, S_CMP, S_EXACT, S_NBR,
    S_LV0, S_LV1, S_LSET, S_MUL, S_DIV, S_FIN, S_OUT
  } stli_state_t;

endpackage

// File: src/stli_if.sv
// ----------------------------------------------------------------------------
// stli_in_if / stli_out_if: valid-ready channels of the interpolator
// One beat moves on a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface stli_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [5:0]  row_index;
  logic [1:0]  column_select;
  logic signed [47:0] entry_value;
  logic signed [47:0] query_altitude;
  modport source (output valid, opcode, row_index, column_select, entry_value,
                  query_altitude, input ready);
  modport sink (input valid, opcode, row_index, column_select, entry_value,
                query_altitude, output ready);
endinterface

interface stli_out_if;
  logic        valid;
  logic        ready;
  logic signed [47:0] result_value;
  logic [1:0]  status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

// File: src/stli_queue.sv
// ----------------------------------------------------------------------------
// stli_queue: two-entry command queue between front and back
// Decouples acceptance of beats from execution.
// ----------------------------------------------------------------------------
module stli_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_data;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && not_empty) rd_ptr <= ~rd_ptr;
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
    end
  end
endmodule

// File: src/stli_front.sv
// ----------------------------------------------------------------------------
// stli_front: input acceptance and classification
// Holds row_count, saturates it per query, forms store addresses for writes.
// ----------------------------------------------------------------------------
module stli_front #(
  parameter int MAX_ROWS = stli_pkg::MAX_ROWS_DEFAULT,
  localparam int AW = $clog2(MAX_ROWS * 4),
  localparam int CW = $clog2(MAX_ROWS + 1),
  localparam int CMD_W = 2 + AW + 2 + stli_pkg::VW + CW
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [stli_pkg::CFG_W-1:0] cfg_wdata,
  stli_in_if.sink                    in_ch,
  output logic                       push,
  output logic [CMD_W-1:0]           push_data,
  input  logic                       full
);
  import stli_pkg::*;

  typedef struct packed {
    logic          op;
    logic          drop;
    logic [AW-1:0] addr;
    logic [1:0]    col;
    logic [VW-1:0] value;
    logic [CW-1:0] rows;
  } cmd_t;

  logic [CFG_W-1:0] row_count;
  logic [31:0]      cfg_wide;
  cmd_t             cmd;

  // Hold the row count register
  always_ff @(posedge clk) begin
    if (rst) row_count <= ROW_COUNT_RESET;
    else if (cfg_we) row_count <= cfg_wdata;
  end

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;
  assign cfg_wide    = 32'(row_count);

  // Classify the beat
  always_comb begin
    cmd.op    = in_ch.opcode;
    cmd.drop  = (32'(in_ch.row_index) >= 32'(MAX_ROWS));
    cmd.addr  = AW'((32'(in_ch.row_index) << 2) | 32'(in_ch.column_select));
    cmd.col   = in_ch.column_select;
    cmd.value = (in_ch.opcode == OP_WRITE) ? in_ch.entry_value : in_ch.query_altitude;
    if (cfg_wide < 32'd2) cmd.rows = CW'(2);
    else if (cfg_wide > 32'(MAX_ROWS)) cmd.rows = CW'(MAX_ROWS);
    else cmd.rows = CW'(cfg_wide);
  end

  assign push_data = cmd;
endmodule

// File: src/stli_back.sv
// ----------------------------------------------------------------------------
// stli_back: table store, binary search sequencer and interpolation unit
// Runs writes and queries one at a time; multiply and divide are bit-serial.
// ----------------------------------------------------------------------------
module stli_back #(
  parameter int MAX_ROWS = stli_pkg::MAX_ROWS_DEFAULT,
  localparam int AW = $clog2(MAX_ROWS * 4),
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = $clog2(MAX_ROWS + 1),
  localparam int CMD_W = 2 + AW + 2 + stli_pkg::VW + CW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  logic [CMD_W-1:0] cmd_data,
  output logic             cmd_pop,
  stli_out_if.source       out_ch
);
  import stli_pkg::*;

  typedef struct packed {
    logic          op;
    logic          drop;
    logic [AW-1:0] addr;
    logic [1:0]    col;
    logic [VW-1:0] value;
    logic [CW-1:0] rows;
  } cmd_t;

  localparam int NW = $clog2(2 * VW);

  cmd_t cmd;
  assign cmd = cmd_data;

  logic [VW-1:0] store [MAX_ROWS * 4];
  logic [VW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  stli_state_t state, state_next;
  logic signed [VW-1:0] x, x_next, km, km_next, klo, klo_next, khi, khi_next;
  logic signed [VW-1:0] v0, v0_next, v1, v1_next, res, res_next;
  logic [1:0]    col, col_next;
  logic [CW-1:0] rows, rows_next, l, l_next, r, r_next;
  logic [RW-1:0] m, m_next, r0, r0_next;
  logic          below, below_next, neg, neg_next;
  logic [VW-1:0] a_sh, a_sh_next, mag, mag_next, dvs, dvs_next, q, q_next;
  logic [VW:0]   rem, rem_next;
  logic [2*VW-1:0] prod, prod_next;
  logic [NW-1:0] cnt, cnt_next;
  status_t       st, st_next;
  logic          out_valid, out_load;
  logic signed [VW-1:0] out_result;
  status_t       out_status;

  logic signed [VW-1:0] rd_s;
  logic [CW:0]   lr_sum;
  logic [RW-1:0] m_calc;
  logic signed [VW:0] dv;
  logic [VW:0]   rem_sh;

  assign rd_s = rd_data;

  // Table store: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) store[cmd.addr] <= cmd.value;
    rd_data <= store[rd_addr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    x <= x_next; km <= km_next; klo <= klo_next; khi <= khi_next;
    v0 <= v0_next; v1 <= v1_next; res <= res_next; col <= col_next;
    rows <= rows_next; l <= l_next; r <= r_next; m <= m_next; r0 <= r0_next;
    below <= below_next; neg <= neg_next; a_sh <= a_sh_next; mag <= mag_next;
    dvs <= dvs_next; q <= q_next; rem <= rem_next; prod <= prod_next;
    cnt <= cnt_next; st <= st_next;
  end

  // Next state and datapath
  always_comb begin
    state_next = state;
    x_next = x; km_next = km; klo_next = klo; khi_next = khi;
    v0_next = v0; v1_next = v1; res_next = res; col_next = col;
    rows_next = rows; l_next = l; r_next = r; m_next = m; r0_next = r0;
    below_next = below; neg_next = neg; a_sh_next = a_sh; mag_next = mag;
    dvs_next = dvs; q_next = q; rem_next = rem; prod_next = prod;
    cnt_next = cnt; st_next = st;
    cmd_pop  = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    rd_addr  = '0;
    lr_sum   = {1'b0, l} + {1'b0, r};
    m_calc   = RW'(lr_sum >> 1);
    dv       = {v1[VW-1], v1} - {v0[VW-1], v0};
    rem_sh   = {rem[VW-1:0], prod[2*VW-1]};
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.op == OP_WRITE) begin
            mem_we = !cmd.drop;
          end else begin
            x_next = cmd.value; col_next = cmd.col; rows_next = cmd.rows;
            rd_addr = '0;
            state_next = S_CHK_LO;
          end
        end
      end
      S_CHK_LO: begin
        if (x < rd_s) begin
          res_next = FIXED_ONE; st_next = ST_RANGE; state_next = S_OUT;
        end else begin
          rd_addr = {RW'(rows - CW'(1)), KEY_COL};
          state_next = S_CHK_HI;
        end
      end
      S_CHK_HI: begin
        if (x > rd_s) begin
          res_next = FIXED_ONE; st_next = ST_RANGE; state_next = S_OUT;
        end else begin
          l_next = '0; r_next = rows; state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        if (l < r) begin
          m_next = m_calc;
          rd_addr = {m_calc, KEY_COL};
          state_next = S_CMP;
        end else begin
          res_next = FIXED_ONE; st_next = ST_FAIL; state_next = S_OUT;
        end
      end
      S_CMP: begin
        km_next = rd_s;
        if (rd_s == x) begin
          rd_addr = {m, col};
          state_next = S_EXACT;
        end else if (x < rd_s) begin
          below_next = 1'b1;
          if (m != '0) begin
            rd_addr = {m - RW'(1), KEY_COL}; state_next = S_NBR;
          end else begin
            r_next = CW'(m); state_next = S_SRCH;
          end
        end else begin
          below_next = 1'b0;
          if ((CW'(m) + CW'(1)) < rows) begin
            rd_addr = {m + RW'(1), KEY_COL}; state_next = S_NBR;
          end else begin
            l_next = CW'(m) + CW'(1); state_next = S_SRCH;
          end
        end
      end
      S_EXACT: begin
        res_next = rd_s; st_next = ST_OK; state_next = S_OUT;
      end
      S_NBR: begin
        if (below) begin
          if (x > rd_s) begin
            r0_next = m - RW'(1); klo_next = rd_s; khi_next = km; state_next = S_LV0;
          end else begin
            r_next = CW'(m); state_next = S_SRCH;
          end
        end else begin
          if (x < rd_s) begin
            r0_next = m; klo_next = km; khi_next = rd_s; state_next = S_LV0;
          end else begin
            l_next = CW'(m) + CW'(1); state_next = S_SRCH;
          end
        end
      end
      S_LV0: begin
        rd_addr = {r0, col}; state_next = S_LV1;
      end
      S_LV1: begin
        v0_next = rd_s;
        rd_addr = {r0 + RW'(1), col}; state_next = S_LSET;
      end
      S_LSET: begin
        v1_next = rd_s; state_next = S_MUL;
        cnt_next = NW'(VW - 1);
        prod_next = '0;
        a_sh_next = x - klo;
        dvs_next = khi - klo;
        neg_next = 1'b0;
        mag_next = '0;
      end
      S_MUL: begin
        // magnitude of the value step, settled on the first multiply cycle
        if (cnt == NW'(VW - 1)) begin
          neg_next = dv[VW];
          mag_next = VW'(dv[VW] ? -dv : dv);
          prod_next = {prod[2*VW-2:0], 1'b0} +
                      (a_sh[VW-1] ? {{VW{1'b0}}, VW'(dv[VW] ? -dv : dv)} : '0);
        end else begin
          prod_next = {prod[2*VW-2:0], 1'b0} + (a_sh[VW-1] ? {{VW{1'b0}}, mag} : '0);
        end
        a_sh_next = {a_sh[VW-2:0], 1'b0};
        if (cnt == '0) begin
          cnt_next = NW'(2 * VW - 1); rem_next = '0; q_next = '0; state_next = S_DIV;
        end else begin
          cnt_next = cnt - NW'(1);
        end
      end
      S_DIV: begin
        // restoring divide, one quotient bit a cycle
        prod_next = {prod[2*VW-2:0], 1'b0};
        if (rem_sh >= {1'b0, dvs}) begin
          rem_next = rem_sh - {1'b0, dvs}; q_next = {q[VW-2:0], 1'b1};
        end else begin
          rem_next = rem_sh; q_next = {q[VW-2:0], 1'b0};
        end
        if (cnt == '0) state_next = S_FIN;
        else cnt_next = cnt - NW'(1);
      end
      S_FIN: begin
        res_next = neg ? v0 - $signed(q) : v0 + $signed(q);
        st_next = ST_OK; state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ch.ready) begin
          out_load = 1'b1; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result <= res;
      out_status <= st;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.result_value = out_result;
  assign out_ch.status       = out_status;
endmodule

// File: src/sorted_table_linear_interpolator_top.sv
// A write is stored by the back end once it leaves its queue slot.
// A query runs the low and high range checks, then binary search steps
// (about log2(rows)+1 steps), then operand loads, multiply, divide and the final add.
// The bit-serial multiply/divide unit serves one query at a time.
// Reset (rst, synchronous): clears control, row_count to 64; table undefined.
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_top: sorted table interpolator
// Front classifies beats, a short queue decouples, back searches and lerps.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator_top #(
  parameter int MAX_ROWS = stli_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [stli_pkg::CFG_W-1:0] cfg_wdata,
  stli_in_if.sink                    in_ch,
  stli_out_if.source                 out_ch
);
  import stli_pkg::*;

  localparam int AW = $clog2(MAX_ROWS * 4);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int CMD_W = 2 + AW + 2 + VW + CW;

  logic             push, full, pop, not_empty;
  logic [CMD_W-1:0] push_data, pop_data;

  stli_front #(.MAX_ROWS(MAX_ROWS)) u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .push(push), .push_data(push_data), .full(full)
  );

  stli_queue #(.WIDTH(CMD_W)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .not_empty(not_empty), .pop_data(pop_data)
  );

  stli_back #(.MAX_ROWS(MAX_ROWS)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(not_empty), .cmd_data(pop_data),
    .cmd_pop(pop), .out_ch(out_ch)
  );
endmodule

// File: src/stli_checker.sv
// ----------------------------------------------------------------------------
// stli_checker: port-level checks of the interpolator
// Watches the result channel for legal status, error values, stall hold and reset.
// ----------------------------------------------------------------------------
module stli_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_result,
  input logic [1:0]  out_status
);
  import stli_pkg::*;

  // Status code 3 is never produced
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status != 2'd3)) else $error("illegal status");

  // Errors return fixed-point one
  a_error_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> (out_result == FIXED_ONE))
    else $error("error result not 1.0");

  // Stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result) && $stable(out_status)))
    else $error("stalled result changed");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind sorted_table_linear_interpolator_top stli_checker u_checker (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_result(out_ch.result_value), .out_status(out_ch.status)
);
